/* hw/rtl/slpc_pkg.sv */
// Shared types and constants for the status LED pattern controller.
// Used by slpc_cfg_regs, slpc_pattern_fsm and the top level.
package slpc_pkg;

  localparam int TIMER_W = 16;
  localparam int CFG_W   = 16;
  localparam int CFG_IDX_W = 3;

  typedef logic [TIMER_W-1:0] timer_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FAST_ON  = 3'd0,
    CFG_FAST_OFF = 3'd1,
    CFG_SLOW_ON  = 3'd2,
    CFG_SLOW_OFF = 3'd3,
    CFG_PULSE    = 3'd4,
    CFG_GAP      = 3'd5
  } cfg_idx_t;

  localparam logic [CFG_W-1:0] RST_FAST_ON  = 16'd40;
  localparam logic [CFG_W-1:0] RST_FAST_OFF = 16'd40;
  localparam logic [CFG_W-1:0] RST_SLOW_ON  = 16'd50;
  localparam logic [CFG_W-1:0] RST_SLOW_OFF = 16'd150;
  localparam logic [CFG_W-1:0] RST_PULSE    = 16'd10;
  localparam logic [CFG_W-1:0] RST_GAP      = 16'd500;

  typedef struct packed {
    logic [CFG_W-1:0] fast_on;
    logic [CFG_W-1:0] fast_off;
    logic [CFG_W-1:0] slow_on;
    logic [CFG_W-1:0] slow_off;
    logic [CFG_W-1:0] pulse;
    logic [CFG_W-1:0] gap;
  } cfg_t;

  // motor_running sits in the lowest bit
  typedef struct packed {
    logic battery_low;
    logic network_healthy;
    logic joined_network;
    logic radio_off;
    logic motor_running;
  } flags_t;

  function automatic timer_t to_timer(logic [CFG_W-1:0] v);
    return TIMER_W'(v);
  endfunction

endpackage

/* hw/rtl/slpc_cfg_regs.sv */
// Configuration register file: six tick durations.
// Depends on slpc_pkg.
module slpc_cfg_regs import slpc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 wr_en,
  input  logic [CFG_IDX_W-1:0] wr_index,
  input  logic [CFG_W-1:0]     wr_data,
  output cfg_t                 cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.fast_on  <= RST_FAST_ON;
      cfg.fast_off <= RST_FAST_OFF;
      cfg.slow_on  <= RST_SLOW_ON;
      cfg.slow_off <= RST_SLOW_OFF;
      cfg.pulse    <= RST_PULSE;
      cfg.gap      <= RST_GAP;
    end else if (wr_en) begin
      unique case (cfg_idx_t'(wr_index))
        CFG_FAST_ON:  cfg.fast_on  <= wr_data;
        CFG_FAST_OFF: cfg.fast_off <= wr_data;
        CFG_SLOW_ON:  cfg.slow_on  <= wr_data;
        CFG_SLOW_OFF: cfg.slow_off <= wr_data;
        CFG_PULSE:    cfg.pulse    <= wr_data;
        CFG_GAP:      cfg.gap      <= wr_data;
        default: ;
      endcase
    end
  end

endmodule

/* hw/rtl/slpc_pattern_fsm.sv */
// Pattern state machine with blink and pulse timers and the LED pin register.
// Depends on slpc_pkg.
module slpc_pattern_fsm import slpc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       advance,
  input  flags_t     flags,
  input  cfg_t       cfg,
  output logic       pin_level,
  output logic [2:0] pattern_state
);

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_ON   = 7'b0000010,
    ST_FAST = 7'b0000100,
    ST_SLOW = 7'b0001000,
    ST_DP0  = 7'b0010000,
    ST_DP1  = 7'b0100000,
    ST_DP2  = 7'b1000000
  } state_t;

  localparam logic [2:0] CODE_IDLE = 3'd0;
  localparam logic [2:0] CODE_ON   = 3'd1;
  localparam logic [2:0] CODE_FAST = 3'd2;
  localparam logic [2:0] CODE_SLOW = 3'd3;
  localparam logic [2:0] CODE_DP0  = 3'd4;
  localparam logic [2:0] CODE_DP1  = 3'd5;
  localparam logic [2:0] CODE_DP2  = 3'd6;

  state_t state, state_next;
  timer_t blink_cnt, blink_cnt_next;
  timer_t pulse_timer, pulse_timer_next;
  logic   led_pin, led_pin_next;
  timer_t blink_dec, pulse_dec;

  assign blink_dec = (blink_cnt != '0) ? blink_cnt - timer_t'(1) : '0;
  assign pulse_dec = (pulse_timer != '0) ? pulse_timer - timer_t'(1) : '0;

  always_comb begin
    state_next       = state;
    blink_cnt_next   = blink_cnt;
    pulse_timer_next = pulse_timer;
    led_pin_next     = led_pin;
    unique case (state)
      ST_IDLE: begin
        if (flags.motor_running) begin
          state_next   = ST_ON;
          led_pin_next = 1'b0;
        end else begin
          blink_cnt_next   = blink_dec;
          pulse_timer_next = pulse_dec;
          if (blink_dec == '0 && !flags.radio_off) begin
            if (!flags.joined_network) begin
              blink_cnt_next = to_timer(cfg.fast_on);
              state_next     = ST_FAST;
              led_pin_next   = 1'b0;
            end else if (!flags.network_healthy) begin
              blink_cnt_next = to_timer(cfg.slow_on);
              state_next     = ST_SLOW;
              led_pin_next   = 1'b0;
            end
          end
          if (flags.battery_low && pulse_dec == '0) begin
            pulse_timer_next = to_timer(cfg.pulse);
            state_next       = ST_DP0;
            led_pin_next     = 1'b0;
          end
        end
      end
      ST_ON: begin
        if (!flags.motor_running) begin
          led_pin_next = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      ST_FAST, ST_SLOW: begin
        blink_cnt_next = blink_dec;
        if (blink_dec == '0) begin
          led_pin_next   = 1'b1;
          blink_cnt_next = to_timer((state == ST_FAST) ? cfg.fast_off : cfg.slow_off);
          state_next     = ST_IDLE;
        end
      end
      ST_DP0: begin
        pulse_timer_next = pulse_dec;
        if (pulse_dec == '0) begin
          pulse_timer_next = to_timer(cfg.pulse);
          led_pin_next     = 1'b1;
          state_next       = ST_DP1;
        end
      end
      ST_DP1: begin
        pulse_timer_next = pulse_dec;
        if (pulse_dec == '0) begin
          pulse_timer_next = to_timer(cfg.pulse);
          led_pin_next     = 1'b0;
          state_next       = ST_DP2;
        end
      end
      ST_DP2: begin
        pulse_timer_next = pulse_dec;
        if (pulse_dec == '0) begin
          pulse_timer_next = to_timer(cfg.gap);
          led_pin_next     = 1'b1;
          state_next       = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      blink_cnt   <= '0;
      pulse_timer <= '0;
      led_pin     <= 1'b0;
    end else if (advance) begin
      state       <= state_next;
      blink_cnt   <= blink_cnt_next;
      pulse_timer <= pulse_timer_next;
      led_pin     <= led_pin_next;
    end
  end

  always_comb begin
    unique case (state)
      ST_IDLE: pattern_state = CODE_IDLE;
      ST_ON:   pattern_state = CODE_ON;
      ST_FAST: pattern_state = CODE_FAST;
      ST_SLOW: pattern_state = CODE_SLOW;
      ST_DP0:  pattern_state = CODE_DP0;
      ST_DP1:  pattern_state = CODE_DP1;
      ST_DP2:  pattern_state = CODE_DP2;
      default: pattern_state = CODE_IDLE;
    endcase
  end

  assign pin_level = led_pin;

endmodule

/* hw/rtl/status_led_pattern_controller_top.sv */
// Status LED pattern controller top level: stream ports, config port, result valid.
// Depends on slpc_pkg, slpc_cfg_regs and slpc_pattern_fsm.
//
//   channel  handshake                  payload
//   s_       s_tvalid / s_tready        s_tdata[4:0]  status flags of one tick
//   m_       m_tvalid / m_tready        m_tdata[3:0]  pin level and pattern state
//   cfg_     cfg_valid / cfg_ready      cfg_index, cfg_data
//
// One tick per cycle while the m_ side is not stalled: the state registers double as the
// result register, so a tick's result shows on m_tdata in the cycle after its transfer in.
// A tick is taken while the result slot is empty or being drained this cycle.
// A stalled m_ side holds the result and the state. Reset is synchronous and
// restores the default durations, idle state, zero timers and pin low.
module status_led_pattern_controller_top import slpc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  // [0] motor_running, [1] radio_off, [2] joined_network,
  // [3] network_healthy, [4] battery_low, [7:5] zero
  input  logic [7:0]           s_tdata,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  // [0] pin_level, [3:1] pattern_state, [7:4] zero
  output logic [7:0]           m_tdata,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  cfg_t       cfg;
  logic       take;
  logic       pin_level;
  logic [2:0] pattern_state;

  assign cfg_ready = 1'b1;
  assign s_tready  = !m_tvalid || m_tready;
  assign take      = s_tvalid && s_tready;

  slpc_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  slpc_pattern_fsm u_fsm (
    .clk           (clk),
    .rst           (rst),
    .advance       (take),
    .flags         (flags_t'(s_tdata[4:0])),
    .cfg           (cfg),
    .pin_level     (pin_level),
    .pattern_state (pattern_state)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (take) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  assign m_tdata = {4'b0000, pattern_state, pin_level};

endmodule

/* tb/sv/status_led_pattern_controller_top_test.sv */
// Self-checking testbench for status_led_pattern_controller_top: directed and random
// status-flag ticks, a tick-by-tick LED pattern predictor and an in-order result check.
// Depends on slpc_pkg and the controller RTL.
module status_led_pattern_controller_top_test;
  import slpc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 200000;
  localparam int MAX_REPORTS = 10;

  typedef enum logic [2:0] {
    LS_IDLE, LS_ON, LS_FAST, LS_SLOW, LS_DP_LIT1, LS_DP_DARK, LS_DP_LIT2
  } led_state_e;

  typedef struct packed {
    logic       pin;
    led_state_e state;
  } led_out_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [7:0]           s_tdata = '0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [7:0]           m_tdata;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;

  flags_t     tick_q[$];
  led_out_t   led_out_q[$];
  int         send_idle_pct = 0;
  int         recv_stall_pct = 0;
  int         mismatches = 0;
  int         cycles = 0;

  logic [CFG_W-1:0] dur_cfg [0:CFG_GAP];
  led_state_e       led_st = LS_IDLE;
  timer_t           blink_left = '0;
  timer_t           pulse_left = '0;
  logic             pin_lvl = 1'b0;

  status_led_pattern_controller_top uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  function automatic void predict_tick(flags_t f);
    led_out_t res;
    case (led_st)
      LS_IDLE: begin
        if (f.motor_running) begin
          led_st = LS_ON;
        end else begin
          if (blink_left != 0) blink_left--;
          if (pulse_left != 0) pulse_left--;
          if (blink_left == 0 && !f.radio_off) begin
            if (!f.joined_network) begin
              blink_left = timer_t'(dur_cfg[CFG_FAST_ON]);
              led_st = LS_FAST;
            end else if (!f.network_healthy) begin
              blink_left = timer_t'(dur_cfg[CFG_SLOW_ON]);
              led_st = LS_SLOW;
            end
          end
          if (f.battery_low && pulse_left == 0) begin
            pulse_left = timer_t'(dur_cfg[CFG_PULSE]);
            led_st = LS_DP_LIT1;
          end
        end
        if (led_st != LS_IDLE) pin_lvl = 1'b0;
      end
      LS_ON: begin
        if (!f.motor_running) begin
          pin_lvl = 1'b1;
          led_st = LS_IDLE;
        end
      end
      LS_FAST, LS_SLOW: begin
        if (blink_left != 0) blink_left--;
        if (blink_left == 0) begin
          pin_lvl = 1'b1;
          blink_left = timer_t'((led_st == LS_FAST) ? dur_cfg[CFG_FAST_OFF]
                                                    : dur_cfg[CFG_SLOW_OFF]);
          led_st = LS_IDLE;
        end
      end
      LS_DP_LIT1, LS_DP_DARK, LS_DP_LIT2: begin
        if (pulse_left != 0) pulse_left--;
        if (pulse_left == 0) begin
          if (led_st == LS_DP_LIT1) begin
            pulse_left = timer_t'(dur_cfg[CFG_PULSE]);
            pin_lvl = 1'b1;
            led_st = LS_DP_DARK;
          end else if (led_st == LS_DP_DARK) begin
            pulse_left = timer_t'(dur_cfg[CFG_PULSE]);
            pin_lvl = 1'b0;
            led_st = LS_DP_LIT2;
          end else begin
            pulse_left = timer_t'(dur_cfg[CFG_GAP]);
            pin_lvl = 1'b1;
            led_st = LS_IDLE;
          end
        end
      end
      default: led_st = LS_IDLE;
    endcase
    res.pin = pin_lvl;
    res.state = led_st;
    led_out_q.push_back(res);
  endfunction

  // tick driver
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) predict_tick(flags_t'(s_tdata[4:0]));
      if (!s_tvalid || s_tready) begin
        if (tick_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          s_tdata <= 8'(tick_q.pop_front());
          s_tvalid <= 1'b1;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    led_out_t exp_out;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (led_out_q.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("unexpected result transfer: pin %b state %0d", m_tdata[0], m_tdata[3:1]);
        end else begin
          exp_out = led_out_q.pop_front();
          if (m_tdata[0] !== exp_out.pin || m_tdata[3:1] !== exp_out.state) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
              $display("result mismatch: expected pin %b state %0d, got pin %b state %0d",
                       exp_out.pin, exp_out.state, m_tdata[0], m_tdata[3:1]);
          end
        end
      end
      m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // call right after a rising edge; the caller lowers cfg_valid after the last write
  task automatic cfg_write(input int idx, input logic [CFG_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_IDX_W'(idx);
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx <= int'(CFG_GAP)) dur_cfg[idx] = val;
  endtask

  task automatic wait_drained();
    while (tick_q.size() != 0 || s_tvalid || led_out_q.size() != 0) @(posedge clk);
  endtask

  function automatic void push_ticks(logic m, logic r, logic j, logic h, logic b, int n);
    repeat (n) tick_q.push_back(flags_t'{b, h, j, r, m});
  endfunction

  initial begin
    flags_t f;
    int     run_len;
    int     pushed;
    logic [CFG_W-1:0] val;

    dur_cfg[CFG_FAST_ON]  = RST_FAST_ON;
    dur_cfg[CFG_FAST_OFF] = RST_FAST_OFF;
    dur_cfg[CFG_SLOW_ON]  = RST_SLOW_ON;
    dur_cfg[CFG_SLOW_OFF] = RST_SLOW_OFF;
    dur_cfg[CFG_PULSE]    = RST_PULSE;
    dur_cfg[CFG_GAP]      = RST_GAP;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // reset durations: pin low while idle after reset, motor priority, pulse beats blink
    push_ticks(0, 1, 1, 1, 0, 1);
    push_ticks(0, 0, 1, 1, 0, 1);
    push_ticks(1, 0, 0, 0, 1, 1);
    push_ticks(1, 1, 1, 0, 1, 1);
    push_ticks(0, 1, 1, 1, 0, 1);
    push_ticks(0, 0, 0, 0, 1, 1);
    push_ticks(0, 0, 0, 0, 0, 2);
    wait_drained();

    // short durations so whole patterns finish
    cfg_write(CFG_FAST_ON, 16'd1);
    cfg_write(CFG_FAST_OFF, 16'd2);
    cfg_write(CFG_SLOW_ON, 16'd3);
    cfg_write(CFG_SLOW_OFF, 16'd1);
    cfg_write(CFG_PULSE, 16'd1);
    cfg_write(CFG_GAP, 16'd4);
    cfg_valid <= 1'b0;
    push_ticks(0, 0, 0, 1, 0, 3);
    push_ticks(0, 0, 1, 0, 0, 4);
    push_ticks(0, 0, 0, 0, 1, 6);
    push_ticks(1, 1, 1, 1, 1, 2);
    push_ticks(0, 0, 1, 1, 0, 2);
    wait_drained();

    // unused register indexes must be ignored
    for (int i = int'(CFG_GAP) + 1; i < 2 ** CFG_IDX_W; i++) cfg_write(i, 16'($urandom));
    cfg_valid <= 1'b0;
    @(posedge clk);

    for (int p = 0; p < 8; p++) begin
      for (int i = CFG_FAST_ON; i <= int'(CFG_GAP); i++) begin
        if (p == 0) begin
          val = '0;
        end else if (p == 1) begin
          val = '1;
        end else begin
          run_len = $urandom_range(0, 9);
          val = (run_len < 7) ? CFG_W'($urandom_range(0, 5)) :
                (run_len < 8) ? '1 : CFG_W'($urandom);
        end
        cfg_write(i, val);
      end
      cfg_valid <= 1'b0;
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 75; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 75; end
        default: begin send_idle_pct = 22; recv_stall_pct = 22; end
      endcase
      pushed = 0;
      while (pushed < 48) begin
        f.motor_running   = ($urandom_range(0, 99) < 12);
        f.radio_off       = ($urandom_range(0, 99) < 20);
        f.joined_network  = ($urandom_range(0, 99) < 55);
        f.network_healthy = ($urandom_range(0, 99) < 50);
        f.battery_low     = ($urandom_range(0, 99) < 30);
        run_len = $urandom_range(1, 10);
        repeat (run_len) tick_q.push_back(f);
        pushed += run_len;
      end
      wait_drained();
    end

    repeat (4) @(posedge clk);
    if (mismatches == 0 && led_out_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

/* filelist.f */
hw/rtl/slpc_pkg.sv
hw/rtl/slpc_cfg_regs.sv
hw/rtl/slpc_pattern_fsm.sv
hw/rtl/status_led_pattern_controller_top.sv
tb/sv/status_led_pattern_controller_top_test.sv
